@@ design/ils_pkg.sv @@
// Shared types and constants for the identifier leak scanner.
`timescale 1ns / 1ps
package ils_pkg;

  localparam int unsigned MAX_TEXT_BYTES_DEF = 1048576;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_HEX_RUN   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DIGIT_RUN = 1'b1;
  localparam logic [CFG_DATA_W-1:0] MIN_HEX_RESET     = 8'd24;
  localparam logic [CFG_DATA_W-1:0] MIN_DIGIT_RESET   = 8'd15;

  localparam int unsigned START_W  = 20;
  localparam int unsigned LENGTH_W = 21;
  localparam int unsigned NUMBER_W = 20;
  localparam logic [NUMBER_W-1:0] NUMBER_MAX = '1;

  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_T      = 8'h74;

  typedef enum logic [1:0] {
    KIND_HEX   = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_DRIVE = 2'd2,
    KIND_USER  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [START_W-1:0]   start;
    logic [LENGTH_W-1:0]  length;
    logic [NUMBER_W-1:0]  number;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } scan_res_t;

endpackage

@@ design/ils_scan.sv @@
// Per-byte scan state and finding detection for the identifier leak scanner.
`timescale 1ns / 1ps
module ils_scan #(
  parameter int unsigned MAX_TEXT_BYTES = ils_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  logic [7:0]                      text_byte,
  input  logic                            end_of_text,
  input  logic [ils_pkg::CFG_DATA_W-1:0]  min_hex,
  input  logic [ils_pkg::CFG_DATA_W-1:0]  min_digit,
  output ils_pkg::scan_res_t              res
);
  import ils_pkg::*;

  localparam int unsigned PW = $clog2(MAX_TEXT_BYTES + 1);
  localparam logic [PW-1:0] MAXV    = PW'(MAX_TEXT_BYTES);
  localparam logic [PW-1:0] LASTPOS = PW'(MAX_TEXT_BYTES - 1);

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v < MAXV) ? v + 1'b1 : MAXV;
  endfunction

  function automatic logic [PW-1:0] clamp_start(input logic [PW-1:0] e,
                                                input logic [PW-1:0] l);
    logic [PW-1:0] s;
    s = (e >= l) ? e - l : '0;
    return (s > LASTPOS) ? LASTPOS : s;
  endfunction

  logic [PW-1:0]        pos_r, pos_nxt;
  logic [PW-1:0]        hex_len_r, hex_len_nxt;
  logic [PW-1:0]        dig_len_r, dig_len_nxt;
  logic [6:0][7:0]      recent_r, recent_nxt;
  logic [NUMBER_W-1:0]  found_r, found_nxt;

  logic is_hex, is_dig, is_letter1;
  logic [PW-1:0] hex_min, dig_min, hex_inc, dig_inc, hex_use, dig_use;
  logic [PW-1:0] hex_end, dig_end, here;
  logic [3:0]    cand_v;
  logic [PW-1:0] cand_start [4];
  logic [PW-1:0] cand_len   [4];
  kind_t         cand_kind  [4];
  logic [NUMBER_W-1:0] num1;

  assign is_hex = (text_byte >= CH_0 && text_byte <= CH_9) ||
                  (text_byte >= CH_LA && text_byte <= CH_LF);
  assign is_dig = (text_byte >= CH_0 && text_byte <= CH_9);
  assign is_letter1 = (recent_r[1] >= CH_UA && recent_r[1] <= CH_UZ) ||
                      (recent_r[1] >= CH_LA && recent_r[1] <= CH_LZ);

  // a minimum of zero behaves as one
  assign hex_min = (min_hex == '0) ? PW'(1) : PW'(min_hex);
  assign dig_min = (min_digit == '0) ? PW'(1) : PW'(min_digit);

  assign hex_inc = sat_inc(hex_len_r);
  assign dig_inc = sat_inc(dig_len_r);
  assign hex_use = is_hex ? hex_inc : hex_len_r;
  assign dig_use = is_dig ? dig_inc : dig_len_r;
  assign hex_end = is_hex ? sat_inc(pos_r) : pos_r;
  assign dig_end = is_dig ? sat_inc(pos_r) : pos_r;
  assign here    = (pos_r > LASTPOS) ? LASTPOS : pos_r;

  always_comb begin
    cand_kind[0] = KIND_HEX;
    cand_kind[1] = KIND_DIGIT;
    cand_kind[2] = KIND_DRIVE;
    cand_kind[3] = KIND_USER;

    cand_v[0] = (!is_hex || end_of_text) && hex_use != '0 && hex_use >= hex_min;
    cand_start[0] = clamp_start(hex_end, hex_use);
    cand_len[0]   = hex_use;

    cand_v[1] = (!is_dig || end_of_text) && dig_use != '0 && dig_use >= dig_min;
    cand_start[1] = clamp_start(dig_end, dig_use);
    cand_len[1]   = dig_use;

    cand_v[2] = (text_byte == CH_SLASH || text_byte == CH_BSLASH) &&
                recent_r[0] == CH_COLON && is_letter1;
    cand_start[2] = (here >= PW'(2)) ? here - PW'(2) : '0;
    cand_len[2]   = PW'(3);

    cand_v[3] = text_byte == CH_LA && recent_r[0] == CH_T && recent_r[1] == CH_LA &&
                recent_r[2] == CH_D && recent_r[3] == CH_R && recent_r[4] == CH_E &&
                recent_r[5] == CH_S && (recent_r[6] == CH_UU || recent_r[6] == CH_LU);
    cand_start[3] = (here >= PW'(7)) ? here - PW'(7) : '0;
    cand_len[3]   = PW'(8);
  end

  assign num1 = (found_r == NUMBER_MAX) ? NUMBER_MAX : found_r + 1'b1;

  // at most two candidates can fire on one byte; pick them in kind order
  always_comb begin
    logic got0, got1;
    got0 = 1'b0;
    got1 = 1'b0;
    res  = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (!got0) begin
          got0 = 1'b1;
          res.first.kind   = cand_kind[i];
          res.first.start  = START_W'(cand_start[i]);
          res.first.length = LENGTH_W'(cand_len[i]);
        end else if (!got1) begin
          got1 = 1'b1;
          res.second.kind   = cand_kind[i];
          res.second.start  = START_W'(cand_start[i]);
          res.second.length = LENGTH_W'(cand_len[i]);
        end
      end
    end
    res.first.number  = found_r;
    res.second.number = num1;
    res.first.last    = got0 && !got1;
    res.second.last   = got1;
    res.cnt           = {got1, got0 && !got1};
  end

  always_comb begin
    pos_nxt     = pos_r;
    hex_len_nxt = hex_len_r;
    dig_len_nxt = dig_len_r;
    recent_nxt  = recent_r;
    found_nxt   = found_r;
    if (fire) begin
      if (end_of_text) begin
        pos_nxt     = '0;
        hex_len_nxt = '0;
        dig_len_nxt = '0;
        recent_nxt  = '0;
        found_nxt   = '0;
      end else begin
        pos_nxt     = sat_inc(pos_r);
        hex_len_nxt = is_hex ? hex_inc : '0;
        dig_len_nxt = is_dig ? dig_inc : '0;
        recent_nxt  = {recent_r[5:0], text_byte};
        case (res.cnt)
          2'd1:    found_nxt = num1;
          2'd2:    found_nxt = (num1 == NUMBER_MAX) ? NUMBER_MAX : num1 + 1'b1;
          default: found_nxt = found_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hex_len_r <= '0;
      dig_len_r <= '0;
      recent_r  <= '0;
      found_r   <= '0;
    end else begin
      pos_r     <= pos_nxt;
      hex_len_r <= hex_len_nxt;
      dig_len_r <= dig_len_nxt;
      recent_r  <= recent_nxt;
      found_r   <= found_nxt;
    end
  end

endmodule

@@ design/ils_outq.sv @@
// Small result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps
module ils_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  ils_pkg::scan_res_t push,
  input  logic               push_en,
  input  logic               pop,
  output logic               room2,
  output logic               head_valid,
  output ils_pkg::result_t   head
);
  import ils_pkg::*;

  localparam int unsigned AW = $clog2(OUTQ_DEPTH);
  localparam int unsigned CW = $clog2(OUTQ_DEPTH + 1);

  result_t         q_r [OUTQ_DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      n_push;

  assign n_push     = push_en ? push.cnt : 2'd0;
  assign room2      = cnt_r <= CW'(OUTQ_DEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = q_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r + AW'(n_push);
    rd_nxt  = rd_r + AW'(pop);
    cnt_nxt = cnt_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_r[wr_r] <= push.first;
    if (n_push == 2'd2) q_r[wr_r + AW'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(OUTQ_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |-> (cnt_r + CW'(n_push) <= CW'(OUTQ_DEPTH)))
    else $error("result queue pushed without room");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("result queue popped while empty");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && n_push == 2'd0 && cnt_r == CW'(1)) |=> !head_valid)
    else $error("result queue not empty after last pop");

endmodule

@@ design/identifier_leak_scanner_core.sv @@
// Top level of the identifier leak scanner.
// Input channel in_*: one text byte per item in in_tdata[7:0]; in_tlast marks the
// last byte of a text, after which all scan state returns to its reset value.
// Result channel out_*: one finding per item (hex run, digit run, drive prefix,
// userdata word) with start offset, length and running finding number;
// out_tlast marks the last finding caused by one byte.
// cfg_*: cfg_addr 0 writes the minimum hex run, 1 the minimum digit run.
// Data path: a byte is held in the input register, is scanned and its findings
// are written to a four-entry result queue, whose head drives out_tvalid and the
// result fields.
// Throughput: one byte per cycle while the queue keeps two free entries; a byte
// that yields two findings puts two entries on the result side, which hands them
// out one at a time, so a long burst of such bytes is paced by the output port.
// Reset (rst_n low, synchronous) empties the queue, clears scan state and
// restores the register defaults. If the receiver stalls, findings stay in the
// queue and in_tready drops once a byte waits while fewer than two entries are free.
`timescale 1ns / 1ps
module identifier_leak_scanner_core #(
  parameter int unsigned MAX_TEXT_BYTES = ils_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] text_byte
  input  logic                            in_tlast,   // end_of_text
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,  // [19:0] match_start,
                                                      // [40:20] match_length,
                                                      // [60:41] finding_number
  output logic [1:0]                      out_tuser,  // [1:0] match_kind
  output logic                            out_tlast,  // last_of_run
  input  logic                            cfg_wr_en,
  input  logic [ils_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ils_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ils_pkg::*;

  logic                  in_v_r;
  logic [7:0]            in_byte_r;
  logic                  in_eot_r;
  logic [CFG_DATA_W-1:0] min_hex_r, min_digit_r;
  logic                  fire, room2, pop;
  scan_res_t             scan_res;
  result_t               head;

  assign fire      = in_v_r && room2;
  assign in_tready = !in_v_r || fire;
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hex_r   <= MIN_HEX_RESET;
      min_digit_r <= MIN_DIGIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_MIN_HEX_RUN:   min_hex_r   <= cfg_wdata;
        CFG_MIN_DIGIT_RUN: min_digit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ils_scan #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .text_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .min_hex     (min_hex_r),
    .min_digit   (min_digit_r),
    .res         (scan_res)
  );

  ils_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (scan_res),
    .push_en    (fire),
    .pop        (pop),
    .room2      (room2),
    .head_valid (out_tvalid),
    .head       (head)
  );

  assign out_tdata = {3'b000, head.number, head.length, head.start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

@@ tb/sv/identifier_leak_scanner_core_tb.sv @@
// Testbench for the identifier leak scanner: finding predictor, byte stream tasks and checks.
`timescale 1ns / 1ps
module identifier_leak_scanner_core_tb;
  import ils_pkg::*;

  class finding_scoreboard;
    logic [7:0]  min_hex;
    logic [7:0]  min_digit;
    int unsigned byte_pos;
    int unsigned hex_len;
    int unsigned digit_len;
    int unsigned found;
    logic [7:0]  window [7];
    result_t     findings_q[$];
    int          errors;

    function new();
      errors = 0;
      min_hex = MIN_HEX_RESET;
      min_digit = MIN_DIGIT_RESET;
      new_text();
    endfunction

    function void new_text();
      byte_pos = 0;
      hex_len = 0;
      digit_len = 0;
      found = 0;
      foreach (window[i]) window[i] = 8'h00;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
      if (addr == CFG_MIN_HEX_RUN) min_hex = val;
      else min_digit = val;
    endfunction

    function int unsigned sat_inc(int unsigned v);
      return (v < MAX_TEXT_BYTES_DEF) ? v + 1 : MAX_TEXT_BYTES_DEF;
    endfunction

    function int unsigned start_of(int unsigned end_excl, int unsigned len);
      int unsigned s;
      s = (end_excl >= len) ? end_excl - len : 0;
      if (s > MAX_TEXT_BYTES_DEF - 1) s = MAX_TEXT_BYTES_DEF - 1;
      return s;
    endfunction

    function void add(kind_t k, int unsigned s, int unsigned len);
      result_t r;
      r.kind = k;
      r.start = s[START_W-1:0];
      r.length = len[LENGTH_W-1:0];
      r.number = found[NUMBER_W-1:0];
      r.last = 1'b0;
      findings_q.push_back(r);
      if (found < NUMBER_MAX) found++;
    endfunction

    // extends a run, or closes it and reports it if long enough
    function int unsigned run_step(int unsigned len, bit member, bit last,
                                   logic [7:0] minimum, kind_t k);
      int unsigned end_excl;
      int unsigned lim;
      end_excl = byte_pos;
      lim = (minimum == 0) ? 1 : minimum;
      if (member) begin
        len = sat_inc(len);
        if (!last) return len;
        end_excl = sat_inc(byte_pos);
      end
      if (len != 0 && len >= lim) add(k, start_of(end_excl, len), len);
      return 0;
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      int unsigned here;
      int unsigned first;
      bit          dig_m;
      bit          hex_m;
      first = findings_q.size();
      here = start_of(byte_pos, 0);
      dig_m = (b >= CH_0 && b <= CH_9);
      hex_m = dig_m || (b >= CH_LA && b <= CH_LF);
      hex_len = run_step(hex_len, hex_m, last, min_hex, KIND_HEX);
      digit_len = run_step(digit_len, dig_m, last, min_digit, KIND_DIGIT);
      if ((b == CH_SLASH || b == CH_BSLASH) && window[0] == CH_COLON &&
          ((window[1] >= CH_UA && window[1] <= CH_UZ) ||
           (window[1] >= CH_LA && window[1] <= CH_LZ)))
        add(KIND_DRIVE, (here >= 2) ? here - 2 : 0, 3);
      if (b == CH_LA && window[0] == CH_T && window[1] == CH_LA && window[2] == CH_D &&
          window[3] == CH_R && window[4] == CH_E && window[5] == CH_S &&
          (window[6] == CH_LU || window[6] == CH_UU))
        add(KIND_USER, (here >= 7) ? here - 7 : 0, 8);
      if (findings_q.size() > first) findings_q[findings_q.size()-1].last = 1'b1;
      if (last) begin
        new_text();
      end else begin
        for (int i = 6; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        byte_pos = sat_inc(byte_pos);
      end
    endfunction

    function void field_check(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (findings_q.size() == 0) begin
        $error("unexpected finding: kind %0d start %0d length %0d", got.kind, got.start,
               got.length);
        errors++;
        return;
      end
      want = findings_q.pop_front();
      field_check("match_kind", want.kind, got.kind);
      field_check("match_start", want.start, got.start);
      field_check("match_length", want.length, got.length);
      field_check("finding_number", want.number, got.number);
      field_check("last_of_run", want.last, got.last);
    endfunction
  endclass

  typedef enum int {SEG_HEX, SEG_DIGIT, SEG_DRIVE, SEG_USER, SEG_NOISE, SEG_GAP} seg_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [63:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  finding_scoreboard sb;
  logic [7:0]        text_q[$];
  result_t           got;
  bit                hold_now;
  bit                calm;

  identifier_leak_scanner_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver: random stall bursts, one long hold on request, none when calm
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_now = 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= rst_n;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = kind_t'(out_tuser);
      got.start = out_tdata[19:0];
      got.length = out_tdata[40:20];
      got.number = out_tdata[60:41];
      got.last = out_tlast;
      sb.check_result(got);
    end
  end

  task automatic send_item(logic [7:0] b, bit last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
  endtask

  // sender pause: drop in_tvalid, wait until every expected finding is out, then idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.findings_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(addr, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_minimums(logic [7:0] hex_min, logic [7:0] digit_min);
    settle();
    write_reg(CFG_MIN_HEX_RUN, hex_min);
    write_reg(CFG_MIN_DIGIT_RUN, digit_min);
  endtask

  // run length around the threshold, so both sides of it are hit
  function automatic int unsigned run_len(logic [7:0] minimum);
    int unsigned t;
    t = ((minimum == 0) ? 1 : minimum) + $urandom_range(0, 6);
    return (t > 3) ? t - 3 : 1;
  endfunction

  task automatic add_segment(seg_t seg);
    string       hex_chars;
    string       word_tail;
    string       gap_chars;
    logic [7:0]  w [8];
    int unsigned n;
    hex_chars = "0123456789abcdef";
    word_tail = "serdata";
    gap_chars = " _GXYZ.-";
    case (seg)
      SEG_HEX: begin
        n = run_len(sb.min_hex);
        repeat (n) text_q.push_back(hex_chars[$urandom_range(0, 15)]);
      end
      SEG_DIGIT: begin
        n = run_len(sb.min_digit);
        repeat (n) text_q.push_back(hex_chars[$urandom_range(0, 9)]);
      end
      SEG_DRIVE: begin
        if ($urandom_range(0, 4) == 0) w[0] = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 1)) w[0] = CH_UA + 8'($urandom_range(0, 25));
        else w[0] = CH_LA + 8'($urandom_range(0, 25));
        w[1] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_COLON;
        if ($urandom_range(0, 4) == 0) w[2] = 8'($urandom_range(0, 255));
        else w[2] = $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
        for (int i = 0; i < 3; i++) text_q.push_back(w[i]);
      end
      SEG_USER: begin
        w[0] = $urandom_range(0, 1) ? CH_UU : CH_LU;
        for (int i = 1; i < 8; i++) w[i] = word_tail[i-1];
        if ($urandom_range(0, 3) == 0) w[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
        foreach (w[i]) text_q.push_back(w[i]);
      end
      SEG_NOISE: begin
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        if ($urandom_range(0, 5) == 0) text_q.push_back(8'h00);
        else text_q.push_back(gap_chars[$urandom_range(0, 7)]);
      end
    endcase
  endtask

  task automatic run_phase(int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) begin
        if (sent + text_q.size() < target) add_segment(seg_t'($urandom_range(0, 5)));
      end
      send_text();
      sent += text_q.size();
    end
  endtask

  initial begin
    string directed;
    sb = new();
    hold_now = 1'b0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    in_tlast <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr <= CFG_MIN_HEX_RUN;
    cfg_wdata <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: both drive separators, upper-case word, zero and 0xFF bytes,
    // then hex and digit runs that both close on the end-of-text byte
    set_minimums(8'd3, 8'd2);
    directed = "a:/Z:\\Userdata";
    text_q.delete();
    for (int i = 0; i < directed.len(); i++) text_q.push_back(directed[i]);
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    directed = "c0ffee123";
    for (int i = 0; i < directed.len(); i++) text_q.push_back(directed[i]);
    send_text();

    set_minimums(MIN_HEX_RESET, MIN_DIGIT_RESET);
    run_phase(100);

    // long receiver hold while bytes keep coming
    set_minimums(8'd1, 8'd1);
    hold_now = 1'b1;
    run_phase(100);

    set_minimums(8'd255, 8'd255);
    run_phase(150);

    set_minimums(8'd0, 8'd0);
    run_phase(100);

    set_minimums(8'($urandom_range(2, 30)), 8'($urandom_range(2, 30)));
    run_phase(60);
    calm = 1'b1;
    run_phase(100);

    in_tvalid <= 1'b0;
    while (sb.findings_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.findings_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
